### rtl/lsfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfe_pkg
// Shared types, codes and brightness tables of the LED strip frame encoder.
// ----------------------------------------------------------------------------
package lsfe_pkg;

    localparam int LED_COUNT_DEF = 64;
    localparam int QUEUE_DEPTH   = 4;
    localparam int OUT_DEPTH     = 2;

    // Driver kinds.
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_WS2801 = 2'd1;
    localparam logic [1:0] KIND_SK9822 = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_DRIVER_KIND = 2'd0;
    localparam logic [1:0] REG_COLOR_ORDER = 2'd1;
    localparam logic [1:0] REG_BRIGHTNESS  = 2'd2;

    // Color orders; any other code gives the grey average.
    localparam logic [2:0] ORDER_RGB = 3'd0;
    localparam logic [2:0] ORDER_RBG = 3'd1;
    localparam logic [2:0] ORDER_GRB = 3'd2;
    localparam logic [2:0] ORDER_GBR = 3'd3;
    localparam logic [2:0] ORDER_BRG = 3'd4;
    localparam logic [2:0] ORDER_BGR = 3'd5;

    localparam logic [2:0] ORDER_RESET = 3'd6;
    localparam logic [1:0] LEVEL_RESET = 2'd3;

    localparam logic [7:0] SK_HDR_MARK = 8'he0;

    // One LED as it leaves the front end: all bytes already final.
    typedef struct packed {
        logic [1:0] kind;
        logic       start;
        logic       keep;
        logic       last;
        logic [7:0] hdr;
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [7:0] ch2;
    } t_led_word;

    // One output byte with its markers.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_frame;
    } t_out_word;

    // WS2801 scale factor; full brightness is handled as a pass-through.
    function automatic logic [7:0] ws_factor(input logic [1:0] lvl);
        logic [7:0] f;
        case (lvl)
            2'd1:    f = 8'd200;
            2'd2:    f = 8'd100;
            2'd3:    f = 8'd50;
            default: f = 8'd0;
        endcase
        return f;
    endfunction

    // Largest value that still scales up to one: 256 divided by the factor.
    function automatic logic [7:0] ws_limit(input logic [1:0] lvl);
        logic [7:0] m;
        case (lvl)
            2'd1:    m = 8'd1;
            2'd2:    m = 8'd2;
            2'd3:    m = 8'd5;
            default: m = 8'd0;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] sk_level(input logic [1:0] lvl);
        logic [4:0] l;
        case (lvl)
            2'd1:    l = 5'd20;
            2'd2:    l = 5'd10;
            2'd3:    l = 5'd5;
            default: l = 5'd31;
        endcase
        return l;
    endfunction

endpackage

### rtl/lsfe_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfe_fifo
// Small register queue with a combinational head, used between the stages.
// ----------------------------------------------------------------------------
module lsfe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]  r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/lsfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfe_front
// Accepts LEDs, holds configuration and the LED counter, reorders and scales
// the channels and hands finished LED words to the queue.
// ----------------------------------------------------------------------------
module lsfe_front #(
    parameter int LED_COUNT = lsfe_pkg::LED_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_addr,
    input  logic [2:0]           i_cfg_data,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [7:0]           i_red,
    input  logic [7:0]           i_green,
    input  logic [7:0]           i_blue,
    input  logic                 i_last_led,
    output logic                 o_word_valid,
    output lsfe_pkg::t_led_word  o_word,
    input  logic                 i_queue_full
);
    import lsfe_pkg::*;

    localparam int CntW = $clog2(LED_COUNT + 1);

    logic [1:0]      r_kind;
    logic [2:0]      r_order;
    logic [1:0]      r_level;
    logic [CntW-1:0] r_led_cnt, n_led_cnt;

    logic            r_v1;
    logic [7:0]      r_ch0, r_ch1, r_ch2;
    logic            r_start, r_keep, r_last;

    logic            accept, advance, keep_now;
    logic [9:0]      sum;
    logic [19:0]     grey_prod;
    logic [7:0]      grey;
    logic [7:0]      c0, c1, c2;
    logic [7:0]      factor, limit;

    assign advance      = !r_v1 || !i_queue_full;
    assign o_full       = !advance;
    assign accept       = i_push && advance;
    assign o_word_valid = r_v1;
    assign keep_now     = (r_led_cnt < CntW'(LED_COUNT));

    // Grey average: sum / 3 as sum * 683 >> 11, exact for sums up to 765.
    assign sum       = {2'b00, i_red} + {2'b00, i_green} + {2'b00, i_blue};
    assign grey_prod = sum * 10'd683;
    assign grey      = grey_prod[18:11];

    always_comb begin
        case (r_order)
            ORDER_RGB: begin c0 = i_red;   c1 = i_green; c2 = i_blue;  end
            ORDER_RBG: begin c0 = i_red;   c1 = i_blue;  c2 = i_green; end
            ORDER_GRB: begin c0 = i_green; c1 = i_red;   c2 = i_blue;  end
            ORDER_GBR: begin c0 = i_green; c1 = i_blue;  c2 = i_red;   end
            ORDER_BRG: begin c0 = i_blue;  c1 = i_red;   c2 = i_green; end
            ORDER_BGR: begin c0 = i_blue;  c1 = i_green; c2 = i_red;   end
            default:   begin c0 = grey;    c1 = grey;    c2 = grey;    end
        endcase
    end

    always_comb begin
        n_led_cnt = r_led_cnt;
        if (accept) begin
            if (i_last_led) begin
                n_led_cnt = '0;
            end else if (keep_now) begin
                n_led_cnt = r_led_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= KIND_NONE;
            r_order   <= ORDER_RESET;
            r_level   <= LEVEL_RESET;
            r_led_cnt <= '0;
            r_v1      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_DRIVER_KIND: r_kind  <= i_cfg_data[1:0];
                    REG_COLOR_ORDER: r_order <= i_cfg_data;
                    REG_BRIGHTNESS:  r_level <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            r_led_cnt <= n_led_cnt;
            if (advance) begin
                r_v1 <= i_push;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch0   <= c0;
            r_ch1   <= c1;
            r_ch2   <= c2;
            r_start <= (r_kind == KIND_SK9822) && (r_led_cnt == '0);
            r_keep  <= keep_now;
            r_last  <= i_last_led;
        end
    end

    // WS2801 brightness scaling of the registered channels.
    function automatic logic [7:0] ws_scale(input logic [7:0] v, input logic [1:0] lvl,
                                            input logic [7:0] f, input logic [7:0] m);
        logic [15:0] prod;
        logic [7:0]  res;
        prod = v * f;
        if (lvl == 2'd0 || v == 8'd0) begin
            res = v;
        end else if (v <= m) begin
            res = 8'd1;
        end else begin
            res = prod[15:8];
        end
        return res;
    endfunction

    assign factor = ws_factor(r_level);
    assign limit  = ws_limit(r_level);

    always_comb begin
        o_word.kind  = r_kind;
        o_word.start = r_start;
        o_word.keep  = r_keep;
        o_word.last  = r_last;
        o_word.hdr   = SK_HDR_MARK | {3'b000, sk_level(r_level)};
        if (r_kind == KIND_WS2801) begin
            o_word.ch0 = ws_scale(r_ch0, r_level, factor, limit);
            o_word.ch1 = ws_scale(r_ch1, r_level, factor, limit);
            o_word.ch2 = ws_scale(r_ch2, r_level, factor, limit);
        end else begin
            o_word.ch0 = r_ch0;
            o_word.ch1 = r_ch1;
            o_word.ch2 = r_ch2;
        end
    end

endmodule

### rtl/lsfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfe_back
// Byte sequencer: walks the start frame, LED bytes and closing frame of the
// queued LED word, one byte per cycle into the output queue while it has room.
// ----------------------------------------------------------------------------
module lsfe_back #(
    parameter int LED_COUNT = lsfe_pkg::LED_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_word_empty,
    input  lsfe_pkg::t_led_word  i_word,
    output logic                 o_word_pop,
    output logic                 o_out_push,
    output lsfe_pkg::t_out_word  o_out,
    input  logic                 i_out_full
);
    import lsfe_pkg::*;

    localparam int TailLen = 4 + LED_COUNT / 16 + 1;
    localparam int CntW    = $clog2(TailLen);

    localparam logic [1:0] SEG_START = 2'd0;
    localparam logic [1:0] SEG_LED   = 2'd1;
    localparam logic [1:0] SEG_TAIL  = 2'd2;
    localparam logic [1:0] SEG_NONE  = 2'd3;

    logic            r_busy, n_busy;
    logic [1:0]      r_seg,  n_seg;
    logic [CntW-1:0] r_cnt,  n_cnt;

    logic            has_start, has_led, has_tail, is_ws;
    logic [1:0]      first_seg, cur_seg, nxt_seg;
    logic [CntW-1:0] cur_cnt;
    logic            seg_end;
    logic [7:0]      cur_byte;

    assign is_ws     = (i_word.kind == KIND_WS2801);
    assign has_start = (i_word.kind == KIND_SK9822) && i_word.start;
    assign has_led   = i_word.keep && (is_ws || i_word.kind == KIND_SK9822);
    assign has_tail  = (i_word.kind == KIND_SK9822) && i_word.last;

    assign first_seg = has_start ? SEG_START :
                       has_led   ? SEG_LED   :
                       has_tail  ? SEG_TAIL  : SEG_NONE;

    assign cur_seg = r_busy ? r_seg : first_seg;
    // WS2801 has no header byte, so its LED segment starts at the first channel.
    assign cur_cnt = r_busy ? r_cnt :
                     ((first_seg == SEG_LED) && is_ws) ? CntW'(1) : '0;

    always_comb begin
        nxt_seg  = SEG_NONE;
        seg_end  = 1'b0;
        cur_byte = 8'd0;
        unique case (cur_seg)
            SEG_START: begin
                seg_end = (cur_cnt == CntW'(3));
                nxt_seg = has_led ? SEG_LED : has_tail ? SEG_TAIL : SEG_NONE;
            end
            SEG_LED: begin
                seg_end = (cur_cnt == CntW'(3));
                nxt_seg = has_tail ? SEG_TAIL : SEG_NONE;
                case (cur_cnt[1:0])
                    2'd0:    cur_byte = i_word.hdr;
                    2'd1:    cur_byte = i_word.ch0;
                    2'd2:    cur_byte = i_word.ch1;
                    default: cur_byte = i_word.ch2;
                endcase
            end
            SEG_TAIL: begin
                seg_end = (cur_cnt == CntW'(TailLen - 1));
            end
            default: ;
        endcase
    end

    always_comb begin
        n_busy     = r_busy;
        n_seg      = r_seg;
        n_cnt      = r_cnt;
        o_word_pop = 1'b0;
        o_out_push = 1'b0;
        o_out.out_byte     = cur_byte;
        o_out.last_of_run  = 1'b0;
        o_out.end_of_frame = 1'b0;
        if (!i_word_empty) begin
            if (cur_seg == SEG_NONE) begin
                // A word that yields no bytes is simply retired.
                o_word_pop = 1'b1;
                n_busy     = 1'b0;
            end else if (!i_out_full) begin
                o_out_push = 1'b1;
                if (seg_end && nxt_seg == SEG_NONE) begin
                    o_word_pop         = 1'b1;
                    n_busy             = 1'b0;
                    o_out.last_of_run  = 1'b1;
                    o_out.end_of_frame = i_word.last;
                end else if (seg_end) begin
                    n_busy = 1'b1;
                    n_seg  = nxt_seg;
                    n_cnt  = '0;
                end else begin
                    n_busy = 1'b1;
                    n_seg  = cur_seg;
                    n_cnt  = cur_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_seg  <= SEG_START;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_seg  <= n_seg;
            r_cnt  <= n_cnt;
        end
    end

endmodule

### rtl/led_strip_frame_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_frame_encoder
// Turns a stream of LED colors into the WS2801 or SK9822 SPI byte stream.
// ----------------------------------------------------------------------------
// An accepted LED is registered in the front end, passes the LED queue and is
// expanded by the byte sequencer into the output queue. The sequencer emits one
// byte per cycle while the output queue has room: an SK9822 LED gives 4 bytes
// (plus 4 start and 4 + LED_COUNT/16 + 1 closing frame bytes), a WS2801 LED 3.
// Reset is synchronous: configuration returns to its defaults, the LED counter
// and all queues are cleared.
module led_strip_frame_encoder #(
    parameter int LED_COUNT = lsfe_pkg::LED_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_addr,
    input  logic [2:0] i_cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic       i_last_led,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_end_of_frame
);
    import lsfe_pkg::*;

    localparam int WordW = $bits(t_led_word);
    localparam int OutW  = $bits(t_out_word);

    t_led_word front_word, queue_word;
    t_out_word back_out, out_head;
    logic      front_valid, queue_full, queue_empty, queue_pop;
    logic      out_push, out_full;

    lsfe_front #(
        .LED_COUNT(LED_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .o_full       (full),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_last_led   (i_last_led),
        .o_word_valid (front_valid),
        .o_word       (front_word),
        .i_queue_full (queue_full)
    );

    lsfe_fifo #(
        .WIDTH(WordW),
        .DEPTH(QUEUE_DEPTH)
    ) u_led_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_word),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_data  (queue_word),
        .o_empty (queue_empty)
    );

    lsfe_back #(
        .LED_COUNT(LED_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_empty (queue_empty),
        .i_word       (queue_word),
        .o_word_pop   (queue_pop),
        .o_out_push   (out_push),
        .o_out        (back_out),
        .i_out_full   (out_full)
    );

    lsfe_fifo #(
        .WIDTH(OutW),
        .DEPTH(OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_out),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_head),
        .o_empty (empty)
    );

    assign o_out_byte     = out_head.out_byte;
    assign o_last_of_run  = out_head.last_of_run;
    assign o_end_of_frame = out_head.end_of_frame;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the LED strip frame encoder against a behavioral predictor of the
// WS2801 and SK9822 byte streams. LEDs go in through the push side. Every
// byte popped from the result side is compared with the oldest predicted
// byte. The sequence covers color orders, brightness scaling, frames longer
// than the strip, back-pressure and random traffic under varying idle rates.
// ----------------------------------------------------------------------------
module tb;
    import lsfe_pkg::*;

    localparam int LED_COUNT     = LED_COUNT_DEF;
    localparam int END_BYTES     = LED_COUNT / 16 + 1;
    localparam int SETTLE_CYCLES = 40;

    localparam logic [1:0] KIND_SPARE     = 2'd3;
    localparam logic [1:0] REG_SPARE      = 2'd3;
    localparam logic [2:0] ORDER_GREY     = 3'd6;
    localparam logic [2:0] ORDER_GREY_ALT = 3'd7;
    localparam logic [1:0] LEVEL_FULL     = 2'd0;
    localparam logic [1:0] LEVEL_HIGH     = 2'd1;
    localparam logic [1:0] LEVEL_MEDIUM   = 2'd2;
    localparam logic [1:0] LEVEL_LOW      = 2'd3;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_cfg_we       = 1'b0;
    logic [1:0] i_cfg_addr     = '0;
    logic [2:0] i_cfg_data     = '0;
    logic       push           = 1'b0;
    logic       full;
    logic [7:0] i_red          = '0;
    logic [7:0] i_green        = '0;
    logic [7:0] i_blue         = '0;
    logic       i_last_led     = 1'b0;
    logic       empty;
    logic       pop            = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;
    logic       o_end_of_frame;

    // Predictor copy of the configuration and the frame position.
    logic [1:0] cur_kind;
    logic [2:0] cur_order;
    logic [1:0] cur_level;
    logic [8:0] leds_in_frame;

    t_out_word expected_bytes[$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_req       = 0;
    int hold_left      = 0;

    led_strip_frame_encoder #(.LED_COUNT(LED_COUNT)) dut (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_addr,
        .i_cfg_data,
        .push,
        .full,
        .i_red,
        .i_green,
        .i_blue,
        .i_last_led,
        .empty,
        .pop,
        .o_out_byte,
        .o_last_of_run,
        .o_end_of_frame
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    function automatic int scale_factor(input logic [1:0] lvl);
        case (lvl)
            LEVEL_HIGH:   return 200;
            LEVEL_MEDIUM: return 100;
            LEVEL_LOW:    return 50;
            default:      return 0;
        endcase
    endfunction

    function automatic logic [7:0] ws_scaled(input logic [7:0] v, input logic [1:0] lvl);
        int f;
        logic [31:0] prod;
        f = scale_factor(lvl);
        if (f == 0 || v == 0) return v;
        if (int'(v) <= 256 / f) return 8'd1;
        prod = int'(v) * f;
        return prod[15:8];
    endfunction

    function automatic logic [4:0] sk_brightness(input logic [1:0] lvl);
        case (lvl)
            LEVEL_HIGH:   return 5'd20;
            LEVEL_MEDIUM: return 5'd10;
            LEVEL_LOW:    return 5'd5;
            default:      return 5'd31;
        endcase
    endfunction

    function automatic t_out_word plain_byte(input logic [7:0] v);
        t_out_word w;
        w.out_byte     = v;
        w.last_of_run  = 1'b0;
        w.end_of_frame = 1'b0;
        return w;
    endfunction

    // Appends the bytes that one accepted LED adds to the stream.
    function automatic void predict_led(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic last);
        logic [7:0] ch [3];
        t_out_word run[$];
        t_out_word w;
        logic keep;
        int grey;
        keep = leds_in_frame < LED_COUNT;
        case (cur_order)
            ORDER_RGB: ch = '{r, g, b};
            ORDER_RBG: ch = '{r, b, g};
            ORDER_GRB: ch = '{g, r, b};
            ORDER_GBR: ch = '{g, b, r};
            ORDER_BRG: ch = '{b, r, g};
            ORDER_BGR: ch = '{b, g, r};
            default: begin
                grey = (int'(r) + int'(g) + int'(b)) / 3;
                ch = '{grey[7:0], grey[7:0], grey[7:0]};
            end
        endcase
        if (cur_kind == KIND_WS2801) begin
            if (keep) begin
                for (int i = 0; i < 3; i++) run.push_back(plain_byte(ws_scaled(ch[i], cur_level)));
            end
        end else if (cur_kind == KIND_SK9822) begin
            if (leds_in_frame == 0) begin
                repeat (4) run.push_back(plain_byte(8'h00));
            end
            if (keep) begin
                run.push_back(plain_byte(SK_HDR_MARK | {3'b000, sk_brightness(cur_level)}));
                for (int i = 0; i < 3; i++) run.push_back(plain_byte(ch[i]));
            end
            if (last) begin
                repeat (4 + END_BYTES) run.push_back(plain_byte(8'h00));
            end
        end
        if (run.size() > 0) begin
            w = run.pop_back();
            w.last_of_run  = 1'b1;
            w.end_of_frame = last;
            run.push_back(w);
        end
        foreach (run[i]) expected_bytes.push_back(run[i]);
        if (last) leds_in_frame = '0;
        else if (leds_in_frame < LED_COUNT) leds_in_frame = leds_in_frame + 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40) $display("%0t ns: %s", $time, what);
    endtask

    // Result side: random pops, with a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : byte_checker
        t_out_word want;
        if (i_rst_n && pop && !empty) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("word %02h popped with nothing expected", o_out_byte));
            end else begin
                want = expected_bytes.pop_front();
                if (o_out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              o_out_byte, want.out_byte));
                if (o_last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %b, expected %b",
                                              o_last_of_run, want.last_of_run));
                if (o_end_of_frame !== want.end_of_frame)
                    report_mismatch($sformatf("end_of_frame %b, expected %b",
                                              o_end_of_frame, want.end_of_frame));
            end
        end
    end

    // Offers one LED, possibly after random idle cycles, and returns once it is taken.
    // Push is left high so that back-to-back words need no second assignment.
    task automatic send_led(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic last);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_red      <= r;
        i_green    <= g;
        i_blue     <= b;
        i_last_led <= last;
        do @(posedge i_clk); while (full);
        predict_led(r, g, b, last);
    endtask

    task automatic send_random_led(input logic last);
        send_led(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                 8'($urandom_range(255, 0)), last);
    endtask

    // Stops offering and waits until every predicted byte has been popped.
    task automatic settle(input int extra);
        push <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [2:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (addr)
            REG_DRIVER_KIND: cur_kind  = data[1:0];
            REG_COLOR_ORDER: cur_order = data;
            REG_BRIGHTNESS:  cur_level = data[1:0];
            default: ;
        endcase
    endtask

    task automatic end_config();
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [1:0] kind, input logic [2:0] order,
                             input logic [1:0] lvl);
        settle(SETTLE_CYCLES);
        write_reg(REG_DRIVER_KIND, {1'b0, kind});
        write_reg(REG_COLOR_ORDER, order);
        write_reg(REG_BRIGHTNESS, {1'b0, lvl});
        write_reg(REG_SPARE, 3'($urandom_range(7, 0)));
        end_config();
    endtask

    // Reset defaults: no output at first, then grey average at low brightness.
    // The frame opened while the driver was off carries on, so no start frame.
    task automatic test_reset_defaults();
        send_led(8'hff, 8'hff, 8'hff, 1'b0);
        settle(SETTLE_CYCLES);
        write_reg(REG_DRIVER_KIND, {1'b0, KIND_SK9822});
        end_config();
        send_led(8'h00, 8'h80, 8'hff, 1'b0);
        send_led(8'h01, 8'h02, 8'h03, 1'b1);
    endtask

    task automatic test_color_orders();
        for (int i = 0; i < 8; i++) begin
            configure(KIND_SK9822, 3'(i), LEVEL_FULL);
            if (3'(i) == ORDER_GREY) send_led(8'hff, 8'hff, 8'hff, 1'b1);
            else if (3'(i) == ORDER_GREY_ALT) send_led(8'hff, 8'hfe, 8'h00, 1'b1);
            else send_led(8'h12, 8'h34, 8'h56, 1'b1);
        end
    endtask

    // Zero, the round-up boundary and just above it at every brightness.
    task automatic test_ws_scaling();
        int f;
        int lim;
        for (int i = 0; i < 4; i++) begin
            configure(KIND_WS2801, ORDER_RGB, 2'(i));
            f   = scale_factor(2'(i));
            lim = (f == 0) ? 0 : 256 / f;
            send_led(8'h00, 8'(lim), 8'hff, 1'b0);
            send_led(8'(lim + 1), 8'h01, 8'h80, 1'b1);
        end
    endtask

    // Frames two LEDs longer than the strip: the extra LEDs must be dropped.
    task automatic test_long_frames();
        configure(KIND_WS2801, 3'($urandom_range(7, 0)), 2'($urandom_range(3, 0)));
        for (int n = 1; n <= LED_COUNT + 2; n++) send_random_led(n == LED_COUNT + 2);
        configure(KIND_SK9822, 3'($urandom_range(7, 0)), 2'($urandom_range(3, 0)));
        for (int n = 1; n <= LED_COUNT + 2; n++) send_random_led(n == LED_COUNT + 2);
    endtask

    // The result side stops for a long stretch while LEDs keep coming, so the
    // internal queues fill and the input must stall.
    task automatic test_backpressure();
        int saved_pct;
        saved_pct = send_idle_pct;
        configure(KIND_SK9822, 3'($urandom_range(7, 0)), 2'($urandom_range(3, 0)));
        send_idle_pct = 0;
        hold_req      = 200;
        for (int n = 1; n <= 30; n++) send_random_led(n == 30);
        send_idle_pct = saved_pct;
    endtask

    // Random configurations and frames; frames may stay open across a change.
    task automatic run_random(input int n_items, input int send_pct, input int recv_pct);
        int done;
        int pick;
        int seg;
        logic [1:0] kind;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(9, 0);
            if (pick == 0) kind = KIND_NONE;
            else if (pick == 1) kind = KIND_SPARE;
            else if (pick < 6) kind = KIND_WS2801;
            else kind = KIND_SK9822;
            configure(kind, 3'($urandom_range(7, 0)), 2'($urandom_range(3, 0)));
            seg = $urandom_range(12, 1);
            repeat (seg) begin
                send_random_led($urandom_range(4, 0) == 0);
                if (kind == KIND_WS2801 || kind == KIND_SK9822) done++;
                if ($urandom_range(19, 0) == 0) settle(0);
            end
        end
    endtask

    initial begin
        cur_kind      = KIND_NONE;
        cur_order     = ORDER_RESET;
        cur_level     = LEVEL_RESET;
        leds_in_frame = '0;
        send_idle_pct = 18;
        recv_idle_pct = 50;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_color_orders();
        test_ws_scaling();
        test_long_frames();
        test_backpressure();
        run_random(40, 18, 50);
        run_random(40, 50, 18);
        run_random(40, 0, 0);

        settle(SETTLE_CYCLES);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/lsfe_pkg.sv
rtl/lsfe_fifo.sv
rtl/lsfe_front.sv
rtl/lsfe_back.sv
rtl/led_strip_frame_encoder.sv
sim/tb.sv
